/* rtl/status_frame_deframer_core_defines.svh */
// ----------------------------------------------------------------------------
// Status frame deframer assertion macros
// Concurrent check helpers for the deframer core, empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef STATUS_FRAME_DEFRAMER_CORE_DEFINES_SVH
`define STATUS_FRAME_DEFRAMER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define SFD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define SFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SFD_ASSERT_SAME(lbl, ante, cons, msg)
`define SFD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

/* rtl/sfd_pkg.sv */
// ----------------------------------------------------------------------------
// Status frame deframer package
// Frame constants, status codes, transfer types and payload placement.
// ----------------------------------------------------------------------------
`default_nettype none

package sfd_pkg;

  localparam logic [7:0] SYNC_BYTE = 8'hAA;
  localparam logic [7:0] FUNC_BYTE = 8'hF1;
  localparam logic [4:0] LAST_POS  = 5'd29;

  localparam logic [1:0] ST_GOOD    = 2'd0;
  localparam logic [1:0] ST_BAD_HDR = 2'd1;
  localparam logic [1:0] ST_BAD_SUM = 2'd2;

  // payload memory entries within one bank
  localparam logic [2:0] ENT_VOLT   = 3'd4;
  localparam logic [2:0] ENT_ENABLE = 3'd5;
  localparam logic [2:0] ENT_CLAW   = 3'd6;
  localparam logic [2:0] ENT_LAST   = 3'd6;
  localparam int unsigned ENT_COUNT = 7;

  typedef struct packed {
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic        [1:0]  frame_status;
    logic signed [31:0] height_one;
    logic signed [31:0] length_one;
    logic signed [31:0] height_two;
    logic signed [31:0] length_two;
    logic        [7:0]  enable_one;
    logic        [7:0]  enable_two;
    logic        [7:0]  enable_three;
    logic        [7:0]  enable_four;
    logic        [7:0]  claw_one;
    logic        [7:0]  claw_two;
    logic signed [31:0] battery_voltage;
  } out_item_t;

  typedef struct packed {
    logic       we;
    logic [2:0] entry;
    logic [1:0] lane;
  } mem_loc_t;

  // map a frame byte position to its payload entry and byte lane
  function automatic mem_loc_t byte_loc(input logic [4:0] pos);
    mem_loc_t   loc;
    logic [4:0] off;
    logic [4:0] voff;
    loc  = '0;
    off  = pos - 5'd3;
    voff = pos - 5'd25;
    if (pos inside {[5'd3:5'd18]}) begin
      loc.we    = 1'b1;
      loc.entry = {1'b0, off[3:2]};
      loc.lane  = off[1:0];
    end else if (pos inside {[5'd19:5'd22]}) begin
      loc.we    = 1'b1;
      loc.entry = ENT_ENABLE;
      loc.lane  = off[1:0];
    end else if (pos inside {[5'd23:5'd24]}) begin
      loc.we    = 1'b1;
      loc.entry = ENT_CLAW;
      loc.lane  = off[1:0];
    end else if (pos inside {[5'd25:5'd28]}) begin
      loc.we    = 1'b1;
      loc.entry = ENT_VOLT;
      loc.lane  = voff[1:0];
    end
    return loc;
  endfunction

endpackage

`default_nettype wire

/* rtl/sfd_if.sv */
// ----------------------------------------------------------------------------
// Status frame deframer stream interfaces
// Valid/ready channels for received bytes and decoded frames.
// ----------------------------------------------------------------------------
`default_nettype none

interface sfd_in_if
  import sfd_pkg::*;
;
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface sfd_out_if
  import sfd_pkg::*;
;
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/status_frame_deframer_core.sv */
// ----------------------------------------------------------------------------
// Status frame deframer core
// Hunts for the sync byte, captures 31-byte status frames, checks the header
// and checksum and delivers one decoded frame per completed frame.
//
// in_ch carries one received byte per transfer; out_ch carries one decoded
// frame (status plus all payload fields) per completed frame. A byte is taken
// every cycle except while the checksum byte is held off. Payload bytes are
// written straight into a two-bank 16 x 32 payload RAM, one byte lane per
// byte; the checksum byte flips the bank and starts a readout of the seven
// entries of the finished bank into the output register. The checksum byte of
// the next frame is held off (in_ch.ready low) only while the previous frame
// is still being read out or waits for the output register, which happens
// only when out_ch stalls. A result stays on out_ch until it transfers. Reset
// clears the hunt state and the readout and output valids; the payload RAM
// keeps its contents and is never read before it is written.
// ----------------------------------------------------------------------------
`default_nettype none
`include "status_frame_deframer_core_defines.svh"

module status_frame_deframer_core
  import sfd_pkg::*;
(
  input  wire         clk,
  input  wire         rst_n,
  sfd_in_if.sink      in_ch,
  sfd_out_if.source   out_ch
);

  logic        collecting_r, collecting_nxt;
  logic [4:0]  idx_r, idx_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic        hdr_ok_r, hdr_ok_nxt;
  logic        wr_bank_r;

  logic [31:0] mem_r [16];
  logic [31:0] rd_data_r;

  logic        rd_busy_r;
  logic [2:0]  rd_cnt_r;
  logic        rd_bank_r;
  logic [1:0]  rd_status_r;
  logic        rd_vld_r;
  logic [2:0]  rd_idx_r;

  logic [31:0] asm_r [ENT_COUNT];
  logic        asm_full_r;
  logic [1:0]  asm_status_r;

  logic        out_valid_r;
  out_item_t   out_data_r;

  logic        in_fire;
  logic        last_byte;
  logic        frame_end;
  logic        pipe_idle;
  logic        out_load;
  logic [7:0]  rx;
  mem_loc_t    loc;
  logic        mem_we;
  logic [1:0]  end_status;
  logic        good;

  assign rx        = in_ch.data.rx_byte;
  assign last_byte = collecting_r && (idx_r == LAST_POS);
  assign pipe_idle = !rd_busy_r && !rd_vld_r && !asm_full_r;
  assign in_ch.ready = !last_byte || pipe_idle;
  assign in_fire   = in_ch.valid && in_ch.ready;
  assign frame_end = in_fire && last_byte;
  assign loc       = byte_loc(idx_r);
  assign mem_we    = in_fire && collecting_r && !last_byte && loc.we;

  always_comb begin
    if (!hdr_ok_r) begin
      end_status = ST_BAD_HDR;
    end else if (sum_r != rx) begin
      end_status = ST_BAD_SUM;
    end else begin
      end_status = ST_GOOD;
    end
  end

  // hunt and frame byte tracking
  always_comb begin
    collecting_nxt = collecting_r;
    idx_nxt        = idx_r;
    sum_nxt        = sum_r;
    hdr_ok_nxt     = hdr_ok_r;
    if (in_fire) begin
      if (!collecting_r) begin
        if (rx == SYNC_BYTE) begin
          collecting_nxt = 1'b1;
          idx_nxt        = '0;
          sum_nxt        = SYNC_BYTE;
          hdr_ok_nxt     = 1'b1;
        end
      end else if (last_byte) begin
        collecting_nxt = 1'b0;
        idx_nxt        = '0;
        sum_nxt        = '0;
        hdr_ok_nxt     = 1'b0;
      end else begin
        if ((idx_r == 5'd0) && (rx != SYNC_BYTE)) begin
          hdr_ok_nxt = 1'b0;
        end
        if ((idx_r == 5'd1) && (rx != FUNC_BYTE)) begin
          hdr_ok_nxt = 1'b0;
        end
        sum_nxt = sum_r + rx;
        idx_nxt = idx_r + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      collecting_r <= 1'b0;
      idx_r        <= '0;
      sum_r        <= '0;
      hdr_ok_r     <= 1'b0;
      wr_bank_r    <= 1'b0;
    end else begin
      collecting_r <= collecting_nxt;
      idx_r        <= idx_nxt;
      sum_r        <= sum_nxt;
      hdr_ok_r     <= hdr_ok_nxt;
      if (frame_end) begin
        wr_bank_r <= !wr_bank_r;
      end
    end
  end

  // payload RAM: byte-lane write, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[{wr_bank_r, loc.entry}][{loc.lane, 3'b000} +: 8] <= rx;
    end
    rd_data_r <= mem_r[{rd_bank_r, rd_cnt_r}];
  end

  // readout sequencer over the finished bank
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_busy_r <= 1'b0;
      rd_cnt_r  <= '0;
      rd_vld_r  <= 1'b0;
    end else begin
      rd_vld_r <= rd_busy_r;
      if (frame_end) begin
        rd_busy_r <= 1'b1;
        rd_cnt_r  <= '0;
      end else if (rd_busy_r) begin
        rd_cnt_r <= rd_cnt_r + 3'd1;
        if (rd_cnt_r == ENT_LAST) begin
          rd_busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r <= rd_cnt_r;
    if (frame_end) begin
      rd_bank_r   <= wr_bank_r;
      rd_status_r <= end_status;
    end
  end

  // assemble the frame, then hand it to the output register
  assign out_load = asm_full_r && (!out_valid_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      asm_full_r <= 1'b0;
    end else if (rd_vld_r && (rd_idx_r == ENT_LAST)) begin
      asm_full_r <= 1'b1;
    end else if (out_load) begin
      asm_full_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_vld_r) begin
      asm_r[rd_idx_r] <= rd_data_r;
    end
    if (rd_vld_r && (rd_idx_r == ENT_LAST)) begin
      asm_status_r <= rd_status_r;
    end
  end

  assign good = (asm_status_r == ST_GOOD);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r.frame_status    <= asm_status_r;
      out_data_r.height_one      <= good ? asm_r[0] : '0;
      out_data_r.length_one      <= good ? asm_r[1] : '0;
      out_data_r.height_two      <= good ? asm_r[2] : '0;
      out_data_r.length_two      <= good ? asm_r[3] : '0;
      out_data_r.battery_voltage <= good ? asm_r[ENT_VOLT] : '0;
      out_data_r.enable_one      <= good ? asm_r[ENT_ENABLE][7:0]   : '0;
      out_data_r.enable_two      <= good ? asm_r[ENT_ENABLE][15:8]  : '0;
      out_data_r.enable_three    <= good ? asm_r[ENT_ENABLE][23:16] : '0;
      out_data_r.enable_four     <= good ? asm_r[ENT_ENABLE][31:24] : '0;
      out_data_r.claw_one        <= good ? asm_r[ENT_CLAW][7:0]     : '0;
      out_data_r.claw_two        <= good ? asm_r[ENT_CLAW][15:8]    : '0;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  `SFD_ASSERT_SAME(a_idx_idle, !collecting_r, idx_r == 5'd0, "index moved while hunting")
  `SFD_ASSERT_SAME(a_rd_no_asm, rd_busy_r, !asm_full_r, "readout started over held frame")
  `SFD_ASSERT_NEXT(a_rd_stop, rd_busy_r && (rd_cnt_r == ENT_LAST), !rd_busy_r,
    "readout overran bank")
  `SFD_ASSERT_NEXT(a_asm_fill, rd_vld_r && (rd_idx_r == ENT_LAST), asm_full_r,
    "frame not assembled after last entry")
  `SFD_ASSERT_SAME(a_bank_split, rd_busy_r && mem_we, rd_bank_r != wr_bank_r,
    "payload write into bank under readout")

endmodule

`default_nettype wire

/* tb/tb_status_frame_deframer_core.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Status frame deframer core testbench
// Streams received bytes into the deframer and checks every decoded frame
// against an in-bench frame decoder or the expected result of a typed table
// row. A short table of hand-built frames covers the field extremes, bad
// header, bad checksum and sync bytes inside a frame. A random part follows:
// mostly complete frames with random content, plus noise bursts and cut-off
// frames. It runs through four phases of source idling and sink stalling.
// ----------------------------------------------------------------------------

module tb_status_frame_deframer_core;
  import sfd_pkg::*;

  localparam int HALF_PERIOD  = 4;
  localparam int RESET_CYCLES = 10;
  localparam int ITEM_TARGET  = 1200;
  localparam int DRAIN_CYCLES = 32;
  localparam int QUIET_LIMIT  = 2000;
  localparam int IDLE_PCT  [4] = '{0, 58, 0, 38};
  localparam int STALL_PCT [4] = '{0, 0, 58, 38};

  typedef enum logic [2:0] {
    FK_GOOD, FK_BAD_SYNC, FK_BAD_FUNC, FK_BAD_BOTH, FK_BAD_SUM
  } frame_kind_t;

  typedef enum logic [2:0] {
    FILL_ZERO, FILL_ONES, FILL_MIN, FILL_MAX, FILL_SYNC, FILL_RAND
  } fill_t;

  typedef logic [7:0] frame_bytes_t [31];

  typedef struct {
    frame_kind_t kind;
    fill_t       fill;
    int          noise;
    bit          typed;
    out_item_t   want;
  } frame_row_t;

  localparam out_item_t WANT_ZERO = '{frame_status: ST_GOOD, default: '0};
  localparam out_item_t WANT_ONES = '{frame_status: ST_GOOD, default: '1};
  localparam out_item_t WANT_HDR  = '{frame_status: ST_BAD_HDR, default: '0};
  localparam out_item_t WANT_SUM  = '{frame_status: ST_BAD_SUM, default: '0};
  localparam out_item_t WANT_MIN  = '{ST_GOOD, 32'h8000_0000, 32'h8000_0000,
                                      32'h8000_0000, 32'h8000_0000, 8'h80, 8'h80,
                                      8'h80, 8'h80, 8'h80, 8'h80, 32'h8000_0000};
  localparam out_item_t WANT_MAX  = '{ST_GOOD, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                      32'h7FFF_FFFF, 32'h7FFF_FFFF, 8'hFF, 8'hFF,
                                      8'hFF, 8'hFF, 8'hFF, 8'hFF, 32'h7FFF_FFFF};

  logic clk = 1'b0;
  logic rst_n;

  sfd_in_if  in_ch ();
  sfd_out_if out_ch ();

  status_frame_deframer_core i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #HALF_PERIOD clk = ~clk;

  // frame decoder state
  bit          in_frame  = 1'b0;
  logic [4:0]  frame_pos = '0;
  logic [7:0]  chk_sum   = '0;
  bit          hdr_good  = 1'b0;
  logic [31:0] word_acc [5];
  logic [7:0]  byte_acc [6];

  out_item_t pending_frames [$];
  out_item_t oldest_frame;
  int        send_idle_pct = 0;
  int        stall_pct     = 0;
  int        mismatches    = 0;
  int        frames_seen   = 0;
  int        bytes_sent    = 0;
  int        live_bytes    = 0;
  int        quiet_cycles  = 0;
  int        status_count [3] = '{0, 0, 0};

  task automatic deframe_byte(input logic [7:0] b, output bit done, output out_item_t res);
    logic [4:0] off;
    done = 1'b0;
    res  = '0;
    off  = frame_pos - 5'd3;
    if (!in_frame) begin
      if (b == SYNC_BYTE) begin
        in_frame  = 1'b1;
        frame_pos = '0;
        chk_sum   = SYNC_BYTE;
        hdr_good  = 1'b1;
      end
    end else if (frame_pos != LAST_POS) begin
      if (frame_pos == 5'd0 && b != SYNC_BYTE) hdr_good = 1'b0;
      if (frame_pos == 5'd1 && b != FUNC_BYTE) hdr_good = 1'b0;
      chk_sum = chk_sum + b;
      if (frame_pos >= 5'd3 && frame_pos <= 5'd18) begin
        word_acc[{1'b0, off[3:2]}] = {b, word_acc[{1'b0, off[3:2]}][31:8]};
      end else if (frame_pos >= 5'd19 && frame_pos <= 5'd24) begin
        byte_acc[3'(frame_pos - 5'd19)] = b;
      end else if (frame_pos >= 5'd25) begin
        word_acc[4] = {b, word_acc[4][31:8]};
      end
      frame_pos = frame_pos + 5'd1;
    end else begin
      in_frame  = 1'b0;
      frame_pos = '0;
      done      = 1'b1;
      if (!hdr_good) begin
        res.frame_status = ST_BAD_HDR;
      end else if (chk_sum != b) begin
        res.frame_status = ST_BAD_SUM;
      end else begin
        res = '{ST_GOOD, word_acc[0], word_acc[1], word_acc[2], word_acc[3],
                byte_acc[0], byte_acc[1], byte_acc[2], byte_acc[3], byte_acc[4],
                byte_acc[5], word_acc[4]};
      end
      chk_sum  = '0;
      hdr_good = 1'b0;
    end
  endtask

  function automatic logic [7:0] other_than(logic [7:0] avoid);
    logic [7:0] b;
    do b = 8'($urandom); while (b == avoid);
    return b;
  endfunction

  function automatic logic [7:0] fill_byte(fill_t fill, int p);
    int  lane;
    bit  top_lane;
    bit  byte_field;
    lane       = (p >= 25) ? p - 25 : p - 3;
    top_lane   = (p >= 3) && (lane % 4 == 3);
    byte_field = (p >= 19) && (p <= 24);
    case (fill)
      FILL_ZERO: return 8'h00;
      FILL_ONES: return 8'hFF;
      FILL_SYNC: return SYNC_BYTE;
      FILL_MIN:  return (byte_field || top_lane) ? 8'h80 : 8'h00;
      FILL_MAX:  return (!byte_field && top_lane) ? 8'h7F : 8'hFF;
      default:   return 8'($urandom);
    endcase
  endfunction

  // sync byte, frame bytes 0..28, checksum byte
  function automatic frame_bytes_t build_frame(frame_kind_t kind, fill_t fill);
    frame_bytes_t f;
    logic [7:0]   sum;
    int           p;
    f[0] = SYNC_BYTE;
    f[1] = SYNC_BYTE;
    f[2] = FUNC_BYTE;
    for (p = 2; p <= 28; p++) f[p + 1] = fill_byte(fill, p);
    if (kind == FK_BAD_SYNC || kind == FK_BAD_BOTH) f[1] = other_than(SYNC_BYTE);
    if (kind == FK_BAD_FUNC || kind == FK_BAD_BOTH) f[2] = other_than(FUNC_BYTE);
    sum = '0;
    for (p = 0; p < 30; p++) sum = sum + f[p];
    f[30] = (kind == FK_BAD_SUM) ? sum + 8'($urandom_range(1, 255)) : sum;
    return f;
  endfunction

  task automatic feed(input logic [7:0] b, input bit typed, input out_item_t want);
    bit        done;
    out_item_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= in_item_t'(b);
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (in_frame || b == SYNC_BYTE) live_bytes++;
    bytes_sent++;
    deframe_byte(b, done, res);
    if (done) pending_frames.push_back(typed ? want : res);
  endtask

  task automatic send_frame(input frame_kind_t kind, input fill_t fill, input int noise,
                            input bit typed, input out_item_t want);
    frame_bytes_t f;
    f = build_frame(kind, fill);
    repeat (noise) feed(other_than(SYNC_BYTE), 1'b0, '0);
    foreach (f[i]) feed(f[i], typed, want);
  endtask

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("ERROR frame %0d %s: got %h, expected %h", frames_seen, field, got, want);
    mismatches++;
  endtask

  task automatic check_frame(input out_item_t got, input out_item_t want);
    if (got.frame_status !== want.frame_status)
      report_mismatch("frame_status", 32'(got.frame_status), 32'(want.frame_status));
    if (got.height_one !== want.height_one)
      report_mismatch("height_one", got.height_one, want.height_one);
    if (got.length_one !== want.length_one)
      report_mismatch("length_one", got.length_one, want.length_one);
    if (got.height_two !== want.height_two)
      report_mismatch("height_two", got.height_two, want.height_two);
    if (got.length_two !== want.length_two)
      report_mismatch("length_two", got.length_two, want.length_two);
    if (got.enable_one !== want.enable_one)
      report_mismatch("enable_one", 32'(got.enable_one), 32'(want.enable_one));
    if (got.enable_two !== want.enable_two)
      report_mismatch("enable_two", 32'(got.enable_two), 32'(want.enable_two));
    if (got.enable_three !== want.enable_three)
      report_mismatch("enable_three", 32'(got.enable_three), 32'(want.enable_three));
    if (got.enable_four !== want.enable_four)
      report_mismatch("enable_four", 32'(got.enable_four), 32'(want.enable_four));
    if (got.claw_one !== want.claw_one)
      report_mismatch("claw_one", 32'(got.claw_one), 32'(want.claw_one));
    if (got.claw_two !== want.claw_two)
      report_mismatch("claw_two", 32'(got.claw_two), 32'(want.claw_two));
    if (got.battery_voltage !== want.battery_voltage)
      report_mismatch("battery_voltage", got.battery_voltage, want.battery_voltage);
  endtask

  // sink side: randomize ready, check each frame transfer
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      frames_seen++;
      if (pending_frames.size() == 0) begin
        report_mismatch("no frame pending, frame_status",
                        32'(out_ch.data.frame_status), '0);
      end else begin
        oldest_frame = pending_frames.pop_front();
        check_frame(out_ch.data, oldest_frame);
      end
      if (out_ch.data.frame_status <= ST_BAD_SUM) status_count[out_ch.data.frame_status]++;
    end
  end

  always @(posedge clk) begin
    if (rst_n !== 1'b1 || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d frames outstanding",
               quiet_cycles, pending_frames.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin : stimulus
    frame_row_t  plan [12];
    frame_kind_t kind;
    fill_t       fill;
    int          phase;
    int          next_phase;
    int          random_start;
    int          pick;
    int          k;

    in_ch.valid  <= 1'b0;
    in_ch.data   <= '0;
    rst_n        <= 1'b0;

    plan = '{
      '{FK_GOOD,     FILL_ZERO, 0, 1'b1, WANT_ZERO},
      '{FK_GOOD,     FILL_ONES, 2, 1'b1, WANT_ONES},
      '{FK_GOOD,     FILL_MIN,  0, 1'b1, WANT_MIN},
      '{FK_GOOD,     FILL_MAX,  1, 1'b1, WANT_MAX},
      '{FK_GOOD,     FILL_SYNC, 0, 1'b0, WANT_ZERO},
      '{FK_BAD_SYNC, FILL_RAND, 0, 1'b1, WANT_HDR},
      '{FK_BAD_FUNC, FILL_RAND, 3, 1'b1, WANT_HDR},
      '{FK_BAD_BOTH, FILL_ONES, 0, 1'b1, WANT_HDR},
      '{FK_BAD_SUM,  FILL_RAND, 0, 1'b1, WANT_SUM},
      '{FK_BAD_SUM,  FILL_ZERO, 0, 1'b1, WANT_SUM},
      '{FK_GOOD,     FILL_RAND, 4, 1'b0, WANT_ZERO},
      '{FK_BAD_FUNC, FILL_SYNC, 0, 1'b1, WANT_HDR}
    };

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[r]) send_frame(plan[r].kind, plan[r].fill, plan[r].noise,
                                 plan[r].typed, plan[r].want);

    phase        = 0;
    random_start = live_bytes;
    while (live_bytes - random_start < ITEM_TARGET) begin
      next_phase = (live_bytes - random_start) * 4 / ITEM_TARGET;
      if (next_phase != phase) begin
        // hold the source until every pending frame has drained
        phase = next_phase;
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_frames.size() != 0) @(posedge clk);
        send_idle_pct = IDLE_PCT[phase];
        stall_pct     = STALL_PCT[phase];
      end
      pick = $urandom_range(99);
      if (pick < 70) begin
        while (in_frame) feed(8'($urandom), 1'b0, '0);
        k    = $urandom_range(99);
        kind = (k < 72) ? FK_GOOD : (k < 80) ? FK_BAD_SYNC : (k < 86) ? FK_BAD_FUNC :
               (k < 90) ? FK_BAD_BOTH : FK_BAD_SUM;
        fill = ($urandom_range(9) == 0) ? fill_t'($urandom_range(0, 4)) : FILL_RAND;
        send_frame(kind, fill, $urandom_range(0, 3), 1'b0, '0);
      end else if (pick < 85) begin
        repeat ($urandom_range(1, 8)) feed(8'($urandom), 1'b0, '0);
      end else begin
        feed(SYNC_BYTE, 1'b0, '0);
        repeat ($urandom_range(1, 29)) feed(8'($urandom), 1'b0, '0);
      end
    end

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d bytes (%0d inside frames), %0d decoded frames, four idle/stall phases",
             bytes_sent, live_bytes, frames_seen);
    $display("decoded mix: %0d good, %0d bad header, %0d bad checksum",
             status_count[ST_GOOD], status_count[ST_BAD_HDR], status_count[ST_BAD_SUM]);
    if (mismatches == 0 && pending_frames.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/sfd_pkg.sv
rtl/sfd_if.sv
rtl/status_frame_deframer_core.sv
tb/tb_status_frame_deframer_core.sv
